// File: src/wmmd_pkg.sv
`timescale 1ns / 1ps

package wmmd_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IN_LENGTH  = 2'd0,
    CFG_OUT_LENGTH = 2'd1
  } cfg_reg_e;

endpackage

// File: src/waveform_minmax_decimator_core.sv
// a result enters the registered output buffer when its sample transaction is accepted
// throughput: one sample per cycle while the output buffer is not full, set by the single state update stage
// a two-entry output buffer keeps input ready while one result waits downstream
// reset: asynchronous active low; lengths return to 1, phase, holds and indexes
// clear, the crossing flag sets, output buffer empties
`timescale 1ns / 1ps

module waveform_minmax_decimator_core
  import wmmd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          block_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [LENGTH_BITS-1:0]        cfg_data_i
);

  localparam int unsigned PhaseBits = LENGTH_BITS + 1;
  localparam int unsigned SumBits   = LENGTH_BITS + 2;

  logic [LENGTH_BITS-1:0] in_length_q, out_length_q;

  logic [PhaseBits-1:0]          phase_q, phase_d;
  logic signed [SAMPLE_BITS-1:0] max_hold_q, max_hold_d;
  logic signed [SAMPLE_BITS-1:0] min_hold_q, min_hold_d;
  logic signed [SAMPLE_BITS-1:0] prior_input_q, prior_input_d;
  logic signed [SAMPLE_BITS-1:0] prior_emitted_q, prior_emitted_d;
  logic signed [SAMPLE_BITS-1:0] first_value_q, first_value_d;
  logic                          crossed_q, crossed_d;
  logic                          max_taken_q, max_taken_d;
  logic                          min_taken_q, min_taken_d;
  logic [LENGTH_BITS-1:0]        out_index_q, out_index_d;
  logic [LENGTH_BITS-1:0]        in_index_q, in_index_d;

  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] emit_value;
  logic                          emit_last;

  logic                          head_vld_q, head_vld_d;
  logic                          skid_vld_q, skid_vld_d;
  logic signed [SAMPLE_BITS-1:0] head_value_q, skid_value_q;
  logic                          head_last_q, skid_last_q;

  logic in_fire, out_fire;

  assign in_ready_o  = !skid_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_length_q  <= LENGTH_BITS'(1);
      out_length_q <= LENGTH_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IN_LENGTH:  in_length_q  <= cfg_data_i;
        CFG_OUT_LENGTH: out_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-sample state update
  always_comb begin
    logic [LENGTH_BITS-1:0]        in_idx0, out_idx0;
    logic [PhaseBits-1:0]          phase0;
    logic signed [SAMPLE_BITS-1:0] max0, min0, prior_in0, prior_em0, first0;
    logic signed [SAMPLE_BITS-1:0] max1, min1, max2, min2, chosen;
    logic                          crossed0, crossed1, maxt0, mint0, take_max;
    logic                          s_pos, s_neg, p_pos, p_neg;
    logic [SumBits-1:0]            phase_sum;

    in_idx0   = block_start_i ? '0 : in_index_q;
    out_idx0  = block_start_i ? '0 : out_index_q;
    phase0    = block_start_i ? '0 : phase_q;
    max0      = block_start_i ? sample_i : max_hold_q;
    min0      = block_start_i ? sample_i : min_hold_q;
    prior_in0 = block_start_i ? sample_i : prior_input_q;
    first0    = block_start_i ? sample_i : first_value_q;
    prior_em0 = block_start_i ? '0 : prior_emitted_q;
    crossed0  = block_start_i ? 1'b1 : crossed_q;
    maxt0     = block_start_i ? 1'b0 : max_taken_q;
    mint0     = block_start_i ? 1'b0 : min_taken_q;

    phase_d         = phase0;
    max_hold_d      = max0;
    min_hold_d      = min0;
    prior_input_d   = prior_in0;
    prior_emitted_d = prior_em0;
    first_value_d   = first0;
    crossed_d       = crossed0;
    max_taken_d     = maxt0;
    min_taken_d     = mint0;
    out_index_d     = out_idx0;
    in_index_d      = in_idx0;

    emit       = 1'b0;
    emit_value = sample_i;
    emit_last  = 1'b0;

    max1      = maxt0 ? sample_i : max0;
    min1      = mint0 ? sample_i : min0;
    max2      = (sample_i > max1) ? sample_i : max1;
    min2      = (sample_i < min1) ? sample_i : min1;
    s_neg     = sample_i[SAMPLE_BITS-1];
    s_pos     = !s_neg && (|sample_i);
    p_neg     = prior_in0[SAMPLE_BITS-1];
    p_pos     = !p_neg && (|prior_in0);
    crossed1  = crossed0 || (s_pos && p_neg) || (s_neg && p_pos);
    phase_sum = SumBits'(phase0) + SumBits'(out_length_q);
    take_max  = (!crossed1) == (!prior_em0[SAMPLE_BITS-1]);
    chosen    = take_max ? max2 : min2;

    if (in_idx0 < in_length_q) begin
      in_index_d = in_idx0 + LENGTH_BITS'(1);
      if (out_length_q >= in_length_q) begin
        emit       = 1'b1;
        emit_value = sample_i;
        emit_last  = (in_index_d == in_length_q);
      end else if (out_idx0 < out_length_q) begin
        max_hold_d    = max2;
        min_hold_d    = min2;
        max_taken_d   = 1'b0;
        min_taken_d   = 1'b0;
        crossed_d     = crossed1;
        prior_input_d = sample_i;
        if (phase_sum < SumBits'(in_length_q)) begin
          phase_d = phase_sum[PhaseBits-1:0];
        end else begin
          phase_d = PhaseBits'(phase_sum - SumBits'(in_length_q));
          if (take_max) begin
            max_hold_d  = sample_i;
            max_taken_d = 1'b1;
          end else begin
            min_hold_d  = sample_i;
            min_taken_d = 1'b1;
          end
          emit_value = chosen;
          if (out_idx0 == '0) begin
            emit_value = first0;
            if (first0 == min_hold_d) begin
              min_taken_d = 1'b1;
            end else begin
              max_taken_d = 1'b1;
            end
          end
          emit            = 1'b1;
          emit_last       = ((out_idx0 + LENGTH_BITS'(1)) == out_length_q);
          out_index_d     = out_idx0 + LENGTH_BITS'(1);
          prior_emitted_d = chosen;
          crossed_d       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= '0;
      max_hold_q      <= '0;
      min_hold_q      <= '0;
      prior_input_q   <= '0;
      prior_emitted_q <= '0;
      first_value_q   <= '0;
      crossed_q       <= 1'b1;
      max_taken_q     <= 1'b0;
      min_taken_q     <= 1'b0;
      out_index_q     <= '0;
      in_index_q      <= '0;
    end else if (in_fire) begin
      phase_q         <= phase_d;
      max_hold_q      <= max_hold_d;
      min_hold_q      <= min_hold_d;
      prior_input_q   <= prior_input_d;
      prior_emitted_q <= prior_emitted_d;
      first_value_q   <= first_value_d;
      crossed_q       <= crossed_d;
      max_taken_q     <= max_taken_d;
      min_taken_q     <= min_taken_d;
      out_index_q     <= out_index_d;
      in_index_q      <= in_index_d;
    end
  end

  // two-entry result buffer: head drives the port, skid catches a stalled transaction
  logic push;
  assign push = in_fire && emit;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    if (out_fire) begin
      if (skid_vld_q) begin
        skid_vld_d = 1'b0;
      end else begin
        head_vld_d = push;
      end
    end else if (push) begin
      if (head_vld_q) begin
        skid_vld_d = 1'b1;
      end else begin
        head_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire && skid_vld_q) begin
      head_value_q <= skid_value_q;
      head_last_q  <= skid_last_q;
    end else if (push && (out_fire || !head_vld_q)) begin
      head_value_q <= emit_value;
      head_last_q  <= emit_last;
    end
    if (push && head_vld_q && !out_fire) begin
      skid_value_q <= emit_value;
      skid_last_q  <= emit_last;
    end
  end

  assign out_valid_o = head_vld_q;
  assign value_o     = head_value_q;
  assign last_o      = head_last_q;

  a_skid_needs_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry held while head entry empty");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> out_valid_o)
    else $error("accepted sample with result produced no output");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && skid_vld_q))
    else $error("input stalled with buffer space free");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_fire && emit)) |=> !out_valid_o)
    else $error("output appeared without an accepted sample");

endmodule
